// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CAP_W   = 5;
    localparam int PRIO_W  = 16;
    localparam int PAY_W   = 32;
    localparam int FUNC_W  = 2;
    localparam int ECNT_W  = 5;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_STATUS = 2'd2,
        FUNC_RSVD   = 2'd3
    } func_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [PAY_W-1:0]  payload;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the queue: holds an entry and shifts or inserts with its neighbors.
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  spq_pkg::entry_t    new_entry,
    input  logic               left_keep,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output logic               keep,
    output spq_pkg::entry_t    entry
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Entries ahead of the new one stay put; ties stay ahead (arrival order).
    assign keep  = occupied && (entry_reg.prio >= new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            if (keep)
                entry_next = entry_reg;
            else if (left_keep)
                entry_next = new_entry;
            else
                entry_next = left_entry;
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/sorted_priority_queue_top.sv =====
// Sorted priority queue built as a chain of insertion/shift cells.
//
// Takes one transaction per clock unless the output stalls: a push, a pop or a
// status request on the slave side, each giving exactly one result on the master
// side in the next cycle. The result sits in an output register, so a new
// request is taken in the same cycle that the previous result is taken. A push
// is placed by every cell comparing its priority with the new one in parallel; a
// pop shifts the whole chain one slot toward the head. Capacity is set via the
// always-ready cfg channel; the user must write it only while idle (not enforced).
module sorted_priority_queue_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [15:0] item_priority, [47:16] item_payload
    input  logic [spq_pkg::IN_W-1:0]   s_tdata,
    // [1:0] func
    input  logic [spq_pkg::FUNC_W-1:0] s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [0] out_valid, [16:1] out_priority, [48:17] out_payload,
    // [53:49] entry_count, [54] is_empty, [55] is_full, [56] op_error, rest zero
    output logic [spq_pkg::OUT_W-1:0]  m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [spq_pkg::CAP_W-1:0]  cfg_data
);
    import spq_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic [OUT_W-1:0] m_tdata_next;

    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] count_next_ext;
    logic             accept;
    func_t            func;
    entry_t           new_entry;
    logic             full_now;
    logic             do_push;
    logic             do_pop;
    logic             push_err;
    logic             pop_err;
    cell_ctrl_t       ctrl;

    logic   [DEPTH-1:0] keep;
    logic   [DEPTH-1:0] occupied;
    entry_t             entries [DEPTH];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign func      = func_t'(s_tuser);
    assign new_entry.prio    = s_tdata[PRIO_W-1:0];
    assign new_entry.payload = s_tdata[PRIO_W+PAY_W-1:PRIO_W];

    // Capacity 0 acts as 1, anything above the built depth as the depth.
    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0)
            eff_cap = CMP_W'(1);
        else if (cap_ext > CMP_W'(DEPTH))
            eff_cap = CMP_W'(DEPTH);
        else
            eff_cap = cap_ext;
    end

    assign count_ext = CMP_W'(count_reg);
    assign full_now  = (count_ext >= eff_cap);
    assign push_err  = accept && (func == FUNC_PUSH) && full_now;
    assign pop_err   = accept && (func == FUNC_POP) && (count_reg == '0);
    assign do_push   = accept && (func == FUNC_PUSH) && !full_now;
    assign do_pop    = accept && (func == FUNC_POP) && (count_reg != '0);
    assign ctrl.push = do_push;
    assign ctrl.pop  = do_pop;

    always_comb
    begin
        priority if (do_push)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop)
            count_next = count_reg - CNT_W'(1);
        else
            count_next = count_reg;
    end

    assign count_next_ext = CMP_W'(count_next);

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic   lk;
            entry_t le;
            entry_t re;

            assign occupied[i] = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_head
                assign lk = 1'b1;
                assign le = new_entry;
            end
            else
            begin : g_body
                assign lk = keep[i-1];
                assign le = entries[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign re = '0;
            end
            else
            begin : g_mid
                assign re = entries[i+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occupied[i]),
                .new_entry   (new_entry),
                .left_keep   (lk),
                .left_entry  (le),
                .right_entry (re),
                .keep        (keep[i]),
                .entry       (entries[i])
            );
        end
    endgenerate

    always_comb
    begin
        m_tdata_next           = '0;
        m_tdata_next[0]        = do_pop;
        if (do_pop)
        begin
            m_tdata_next[16:1]  = entries[0].prio;
            m_tdata_next[48:17] = entries[0].payload;
        end
        m_tdata_next[53:49]    = ECNT_W'(count_next);
        m_tdata_next[54]       = (count_next == '0);
        m_tdata_next[55]       = (count_next_ext >= eff_cap);
        m_tdata_next[56]       = push_err || pop_err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_W'(16);
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            count_reg <= count_next;
            if (accept)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [spq_pkg::OUT_W-1:0]  m_tdata
);
    import spq_pkg::*;

    // Each accepted request yields a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted transaction produced no result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[54] == (m_tdata[53:49] == '0)))
        else $error("empty flag disagrees with count");

    a_valid_vs_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[56]))
        else $error("entry returned on a refused operation");

    a_no_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[48:1] == '0))
        else $error("entry fields not zero without a returned entry");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);
